@@ sv/sba_pkg.sv @@
// shared types and constants for the sky brightness accumulator
package sba_pkg;

    typedef enum logic [2:0] {
        ST_ACCUM    = 3'd0,
        ST_REJECT   = 3'd1,
        ST_READING  = 3'd2,
        ST_NOREAD   = 3'd3,
        ST_LINK_ERR = 3'd4
    } step_status_t;

    typedef enum logic [2:0] {
        CFG_MIN_SAMPLES = 3'd0,
        CFG_MAX_SAMPLES = 3'd1,
        CFG_MIN_VIS     = 3'd2,
        CFG_SQM_OFS     = 3'd3,
        CFG_FILT_OFS    = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_LOG_NORM,
        BK_LOG_SQ,
        BK_LOG_CHK,
        BK_LOG_NEXT,
        BK_MUL,
        BK_MUL_ACC,
        BK_FINISH,
        BK_OUT
    } back_state_t;

    localparam logic [14:0] NORM_COUNT = 15'd29628;
    localparam logic signed [19:0] BASE_MILLI = 20'sd12600;
    localparam logic [25:0] SLOPE_LN2_Q16 = 26'd49332738;
    localparam int SLOPE_BITS = 26;

endpackage

@@ sv/sba_front.sv @@
// front end: accepts samples, keeps the running sums and classifies each sample
module sba_front
#(
    parameter int COUNT_BITS = 16,
    parameter int SUM_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         full_count,
    input  logic [15:0]         ir_count,
    input  logic                link_error,
    input  logic [7:0]          min_samples,
    input  logic [7:0]          max_samples,
    input  logic [23:0]         min_visible_sum,
    output logic                q_valid,
    input  logic                q_ready,
    output sba_pkg::step_status_t q_status,
    output logic [SUM_BITS-1:0] q_full_sum,
    output logic [SUM_BITS-1:0] q_ir_sum,
    output logic [SUM_BITS-1:0] q_vis_sum,
    output logic [7:0]          q_count
);
    import sba_pkg::*;

    logic [SUM_BITS-1:0] full_sum_reg, full_sum_next;
    logic [SUM_BITS-1:0] ir_sum_reg, ir_sum_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic                qv_reg;
    step_status_t        qs_reg, qs_next;
    logic [SUM_BITS-1:0] qf_reg, qi_reg, qvis_reg;
    logic [7:0]          qc_reg;

    logic [COUNT_BITS-1:0] full_m, ir_m;
    logic [SUM_BITS-1:0]   fs_add, is_add, vis;
    logic [7:0]            cnt_add;
    logic                  accept;

    assign full_m = full_count[COUNT_BITS-1:0];
    assign ir_m = ir_count[COUNT_BITS-1:0];
    assign in_ready = !qv_reg || q_ready;
    assign accept = in_valid && in_ready;
    assign fs_add = full_sum_reg + SUM_BITS'(full_m);
    assign is_add = ir_sum_reg + SUM_BITS'(ir_m);
    assign cnt_add = cnt_reg + 8'd1;
    assign vis = fs_add - is_add;

    always_comb
    begin
        full_sum_next = full_sum_reg;
        ir_sum_next = ir_sum_reg;
        cnt_next = cnt_reg;
        qs_next = ST_ACCUM;
        if (link_error)
        begin
            full_sum_next = '0;
            ir_sum_next = '0;
            cnt_next = '0;
            qs_next = ST_LINK_ERR;
        end
        else if (full_m < ir_m)
        begin
            qs_next = ST_REJECT;
        end
        else
        begin
            full_sum_next = fs_add;
            ir_sum_next = is_add;
            cnt_next = cnt_add;
            if (cnt_add < min_samples ||
                ({{(32-SUM_BITS){1'b0}}, vis} < {8'd0, min_visible_sum} &&
                 cnt_add < max_samples))
                qs_next = ST_ACCUM;
            else
            begin
                full_sum_next = '0;
                ir_sum_next = '0;
                cnt_next = '0;
                if (vis != '0 && cnt_add != 8'd0)
                    qs_next = ST_READING;
                else
                    qs_next = ST_NOREAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_sum_reg <= '0;
            ir_sum_reg <= '0;
            cnt_reg <= '0;
            qv_reg <= 1'b0;
            qs_reg <= ST_ACCUM;
        end
        else
        begin
            if (accept)
            begin
                full_sum_reg <= full_sum_next;
                ir_sum_reg <= ir_sum_next;
                cnt_reg <= cnt_next;
                qs_reg <= qs_next;
                qv_reg <= 1'b1;
            end
            else if (q_ready)
                qv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qf_reg <= fs_add;
            qi_reg <= is_add;
            qvis_reg <= vis;
            qc_reg <= cnt_add;
        end
    end

    assign q_valid = qv_reg;
    assign q_status = qs_reg;
    assign q_full_sum = qf_reg;
    assign q_ir_sum = qi_reg;
    assign q_vis_sum = qvis_reg;
    assign q_count = qc_reg;
endmodule

@@ sv/sba_back.sv @@
// back end: serial averages, iterative log and the held reading
module sba_back
#(
    parameter int SUM_BITS = 24,
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  sba_pkg::step_status_t q_status,
    input  logic [SUM_BITS-1:0] q_full_sum,
    input  logic [SUM_BITS-1:0] q_ir_sum,
    input  logic [SUM_BITS-1:0] q_vis_sum,
    input  logic [7:0]          q_count,
    input  logic signed [15:0]  sqm_offset_milli,
    input  logic signed [15:0]  filter_offset_milli,
    output logic                out_valid,
    input  logic                out_ready,
    output sba_pkg::step_status_t step_status,
    output logic                reading_valid,
    output logic signed [17:0]  brightness_milli,
    output logic [15:0]         full_average,
    output logic [15:0]         ir_average,
    output logic [15:0]         visible_average
);
    import sba_pkg::*;

    localparam int LW = 32;              // log operand width
    localparam int EW = 5;
    localparam int MW = LOG_FRAC_BITS + 2;
    localparam int LRW = EW + LOG_FRAC_BITS + 1;
    localparam int PW = LRW + SLOPE_BITS;
    localparam int SH = LOG_FRAC_BITS + 16;
    localparam int DW = $clog2(SUM_BITS + 1);
    localparam int FW = $clog2(LOG_FRAC_BITS + 1);

    back_state_t st_reg, st_next;
    step_status_t stat_reg;
    logic [SUM_BITS-1:0] fq_reg, iq_reg, vq_reg;
    logic [SUM_BITS-1:0] fr_reg, ir_reg, vr_reg;
    logic [7:0]          n_reg;
    logic [DW-1:0]       dcnt_reg;
    logic                lpass_reg;
    logic [LW-1:0]       lv_reg;
    logic [EW-1:0]       e_reg;
    logic [MW-1:0]       m_reg;
    logic [2*MW-1:0]     sq_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [FW-1:0]       it_reg;
    logic signed [LRW-1:0] log1_reg, d_reg;
    logic [LRW-1:0]      dmag_reg;
    logic                dneg_reg;
    logic [PW-1:0]       prod_reg;
    logic signed [17:0]  hb_reg;
    logic [15:0]         hf_reg, hi_reg, hv_reg;
    logic                hval_reg;
    logic                ov_reg;
    logic                q_take;

    // a new transfer is taken only once the held result is gone or leaving
    assign q_take = (st_reg == BK_IDLE) && q_valid && (!ov_reg || out_ready);

    // restoring divider step, all three sums share the divisor
    function automatic logic [SUM_BITS:0] div_step(logic [SUM_BITS-1:0] r,
                                                   logic [SUM_BITS-1:0] q,
                                                   logic [7:0] d);
        logic [8:0] t;
        logic [8:0] rr;
        begin
            rr = {r[7:0], q[SUM_BITS-1]};
            t = rr - {1'b0, d};
            if (!t[8])
                div_step = {1'b1, {(SUM_BITS-8){1'b0}}, t[7:0]};
            else
                div_step = {1'b0, {(SUM_BITS-8){1'b0}}, rr[7:0]};
        end
    endfunction

    logic [SUM_BITS:0] fs, is, vs;
    assign fs = div_step(fr_reg, fq_reg, n_reg);
    assign is = div_step(ir_reg, iq_reg, n_reg);
    assign vs = div_step(vr_reg, vq_reg, n_reg);

    // leading one position
    logic [EW-1:0] lead;
    always_comb
    begin
        lead = '0;
        for (int k = 0; k < LW; k++)
            if (lv_reg[k])
                lead = EW'(k);
    end

    logic [LW+LOG_FRAC_BITS-1:0] norm_wide;
    assign norm_wide = {lv_reg, {LOG_FRAC_BITS{1'b0}}} >> lead;

    logic [2*MW-1:0] sq_sh;
    assign sq_sh = sq_reg >> LOG_FRAC_BITS;

    logic [LRW-1:0] log_val;
    assign log_val = {1'b0, e_reg, frac_reg};

    logic signed [19:0] term, bsum;
    logic [PW-SH-1:0]   rnd;
    assign rnd = (PW-SH)'((prod_reg + (PW'(1) << (SH - 1))) >> SH);
    assign term = dneg_reg ? -20'(signed'({1'b0, rnd})) : 20'(signed'({1'b0, rnd}));
    assign bsum = BASE_MILLI - term + 20'(sqm_offset_milli) + 20'(filter_offset_milli);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:
                if (q_take)
                    st_next = (q_status == ST_READING) ? BK_DIV : BK_OUT;
            BK_DIV:
                if (dcnt_reg == DW'(SUM_BITS - 1))
                    st_next = BK_LOG_NORM;
            BK_LOG_NORM: st_next = BK_LOG_SQ;
            BK_LOG_SQ:   st_next = BK_LOG_CHK;
            BK_LOG_CHK:  st_next = BK_LOG_NEXT;
            BK_LOG_NEXT:
                if (it_reg == FW'(LOG_FRAC_BITS))
                    st_next = lpass_reg ? BK_MUL : BK_LOG_NORM;
                else
                    st_next = BK_LOG_SQ;
            BK_MUL:      st_next = BK_MUL_ACC;
            BK_MUL_ACC:  st_next = BK_FINISH;
            BK_FINISH:   st_next = BK_OUT;
            BK_OUT:
                if (!ov_reg)
                    st_next = BK_IDLE;
            default:     st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready = (st_reg == BK_IDLE) && (!ov_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            hb_reg <= '0;
            hf_reg <= '0;
            hi_reg <= '0;
            hv_reg <= '0;
            hval_reg <= 1'b0;
            ov_reg <= 1'b0;
            stat_reg <= ST_ACCUM;
        end
        else
        begin
            st_reg <= st_next;
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            if (q_take)
            begin
                stat_reg <= q_status;
                if (q_status == ST_LINK_ERR)
                    hval_reg <= 1'b0;
            end
            if (st_reg == BK_LOG_NORM && lpass_reg)
            begin
                hf_reg <= fq_reg[15:0];
                hi_reg <= iq_reg[15:0];
                hv_reg <= vq_reg[15:0];
            end
            if (st_reg == BK_FINISH)
            begin
                if (bsum > 20'sd131071)
                    hb_reg <= 18'sd131071;
                else if (bsum < -20'sd131072)
                    hb_reg <= -18'sd131072;
                else
                    hb_reg <= bsum[17:0];
                hval_reg <= 1'b1;
            end
            if (st_reg == BK_OUT && !ov_reg)
                ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            BK_IDLE:
            begin
                fq_reg <= q_full_sum;
                iq_reg <= q_ir_sum;
                vq_reg <= q_vis_sum;
                fr_reg <= '0;
                ir_reg <= '0;
                vr_reg <= '0;
                n_reg <= q_count;
                dcnt_reg <= '0;
                lpass_reg <= 1'b0;
                lv_reg <= LW'(q_vis_sum);
            end
            BK_DIV:
            begin
                fr_reg <= {{(SUM_BITS-8){1'b0}}, fs[7:0]};
                ir_reg <= {{(SUM_BITS-8){1'b0}}, is[7:0]};
                vr_reg <= {{(SUM_BITS-8){1'b0}}, vs[7:0]};
                fq_reg <= {fq_reg[SUM_BITS-2:0], fs[SUM_BITS]};
                iq_reg <= {iq_reg[SUM_BITS-2:0], is[SUM_BITS]};
                vq_reg <= {vq_reg[SUM_BITS-2:0], vs[SUM_BITS]};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            BK_LOG_NORM:
            begin
                e_reg <= lead;
                m_reg <= norm_wide[MW-1:0];
                frac_reg <= '0;
                it_reg <= '0;
            end
            BK_LOG_SQ:
                sq_reg <= m_reg * m_reg;
            BK_LOG_CHK:
            begin
                if (sq_sh[MW-1])
                begin
                    m_reg <= sq_sh[MW:1];
                    frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    m_reg <= sq_sh[MW-1:0];
                    frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], 1'b0};
                end
                it_reg <= it_reg + 1'b1;
            end
            BK_LOG_NEXT:
                if (it_reg == FW'(LOG_FRAC_BITS))
                begin
                    if (!lpass_reg)
                    begin
                        log1_reg <= log_val;
                        lv_reg <= LW'(NORM_COUNT) * LW'(n_reg);
                        lpass_reg <= 1'b1;
                    end
                    else
                        d_reg <= log1_reg - log_val;
                end
            BK_MUL:
            begin
                dneg_reg <= d_reg[LRW-1];
                dmag_reg <= d_reg[LRW-1] ? LRW'(-d_reg) : LRW'(d_reg);
            end
            BK_MUL_ACC:
                prod_reg <= PW'(dmag_reg) * PW'(SLOPE_LN2_Q16);
            default: ;
        endcase
    end

    assign out_valid = ov_reg;
    assign step_status = stat_reg;
    assign reading_valid = hval_reg;
    assign brightness_milli = hb_reg;
    assign full_average = hf_reg;
    assign ir_average = hi_reg;
    assign visible_average = hv_reg;
endmodule

@@ sv/sky_brightness_accumulator.sv @@
// top level of the sky brightness accumulator
// samples come in on s_axis: tdata {ir_count, full_count}, tuser link_error.
// results leave on m_axis, one per sample, showing the held reading.
// a front stage keeps the running sums and classifies each sample; a
// one-entry queue hands it to a back end. samples without a reading go
// straight to the output state. a closing series with a reading runs a
// serial divider for the three averages, two log2 passes that square and
// check once per fraction bit, and a multiply and round.
// reset clears the sums, the held reading and the valid bit and loads the
// register defaults. a stalled receiver holds the result; the front accepts
// one more sample into the queue and then holds s_axis_tready low.
// configuration writes through cfg_we/cfg_index/cfg_wdata; the user must
// write only while idle, as the block itself does not enforce it.
module sky_brightness_accumulator
#(
    parameter int COUNT_BITS = 16,
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // full_count, ir_count
    input  logic        s_axis_tuser,   // link_error
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // step_status, reading_valid, brightness_milli,
                                        // full_average, ir_average, visible_average
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import sba_pkg::*;

    localparam int SUM_BITS = COUNT_BITS + 8;

    logic [7:0]         min_s_reg, max_s_reg;
    logic [23:0]        min_v_reg;
    logic signed [15:0] sqm_reg, filt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_s_reg <= 8'd5;
            max_s_reg <= 8'd150;
            min_v_reg <= 24'd500;
            sqm_reg <= '0;
            filt_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_SAMPLES: min_s_reg <= cfg_wdata[7:0];
                CFG_MAX_SAMPLES: max_s_reg <= cfg_wdata[7:0];
                CFG_MIN_VIS:     min_v_reg <= cfg_wdata;
                CFG_SQM_OFS:     sqm_reg <= cfg_wdata[15:0];
                CFG_FILT_OFS:    filt_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic                q_valid, q_ready;
    step_status_t        q_status, st;
    logic [SUM_BITS-1:0] q_f, q_i, q_v;
    logic [7:0]          q_c;
    logic                rv;
    logic signed [17:0]  bm;
    logic [15:0]         fa, ia, va;

    sba_front #(.COUNT_BITS(COUNT_BITS), .SUM_BITS(SUM_BITS)) u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .full_count(s_axis_tdata[15:0]), .ir_count(s_axis_tdata[31:16]),
        .link_error(s_axis_tuser),
        .min_samples(min_s_reg), .max_samples(max_s_reg), .min_visible_sum(min_v_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_status(q_status),
        .q_full_sum(q_f), .q_ir_sum(q_i), .q_vis_sum(q_v), .q_count(q_c)
    );

    sba_back #(.SUM_BITS(SUM_BITS), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_status(q_status),
        .q_full_sum(q_f), .q_ir_sum(q_i), .q_vis_sum(q_v), .q_count(q_c),
        .sqm_offset_milli(sqm_reg), .filter_offset_milli(filt_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .step_status(st), .reading_valid(rv), .brightness_milli(bm),
        .full_average(fa), .ir_average(ia), .visible_average(va)
    );

    assign m_axis_tdata = {2'b00, va, ia, fa, bm, rv, st};

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd5 && m_axis_tdata[2:0] != 3'd6 &&
                           m_axis_tdata[2:0] != 3'd7))
        else $error("bad status");
    a_link_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && st == ST_LINK_ERR) |-> !rv)
        else $error("valid after link error");
    a_reading_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && st == ST_READING) |-> rv)
        else $error("reading not valid");
endmodule
